[rtl/fatcw_pkg.sv]
// ----------------------------------------------------------------------------
// fatcw_pkg
// Types and constants shared by the cluster chain walker.
// ----------------------------------------------------------------------------
package fatcw_pkg;

    // table geometry and walk limit
    localparam int FAT_ENTRIES = 4096;
    localparam int FAT_AW      = $clog2(FAT_ENTRIES);
    localparam int MAX_RUN     = 64;
    localparam int CNT_W       = $clog2(MAX_RUN + 1);

    // field widths
    localparam int CLUSTER_W = 12;
    localparam int ENTRY_W   = 28;
    localparam int RUN_W     = 7;

    // entry marks
    localparam logic [ENTRY_W-1:0] END_MIN  = 28'hFFF_FFF8;
    localparam logic [ENTRY_W-1:0] BAD_MARK = 28'hFFF_FFF7;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_WALK  = 1'b1;

    typedef enum logic [1:0] {
        ST_END   = 2'd0,
        ST_BAD   = 2'd1,
        ST_CAP   = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef struct packed {
        logic                 req_type;
        logic [CLUSTER_W-1:0] entry_index;
        logic [ENTRY_W-1:0]   entry_value;
        logic [CLUSTER_W-1:0] start_cluster;
        logic [RUN_W-1:0]     run_length;
    } t_req;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster_number;
        logic                 last;
        t_status              status;
    } t_rsp;

endpackage

[rtl/fat_cluster_chain_walker_unit.sv]
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker_unit
// Allocation table with 28-bit entries and a sequencer that follows a
// cluster chain one table read per cycle, emitting each cluster.
// ----------------------------------------------------------------------------
//  channel   | signals              | flow control
//  ----------+----------------------+-------------------------------------
//  request   | start, i_req         | taken when start high and busy low
//  result    | o_valid, o_rsp       | one-cycle strobe, no back pressure
//
//  a write transaction leaves busy low
//  a walk keeps busy high while its steps run: the table read port
//  gives one entry per cycle and each entry yields one result
//  results leave through an output register, in the cycle after their step
//  a start cluster out of table range gives one result and leaves busy low
//  reset is synchronous; table contents are undefined until written
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  fatcw_pkg::t_req i_req,
    output logic            busy,
    output logic            o_valid,
    output fatcw_pkg::t_rsp o_rsp
);
    import fatcw_pkg::*;

    logic [ENTRY_W-1:0] r_mem [FAT_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;

    t_state               r_state, n_state;
    logic [ENTRY_W-1:0]   r_cl, n_cl;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_limit, n_limit;
    t_status              r_lim_st, n_lim_st;
    logic                 r_out_valid, n_out_valid;
    t_rsp                 r_out, n_out;

    logic                 w_accept;
    logic                 w_we;
    logic [FAT_AW-1:0]    w_rd_addr;
    logic                 w_start_oor;
    logic                 w_is_end, w_is_bad, w_count_done, w_next_oor;

    assign w_accept    = start && !busy;
    assign w_we        = w_accept && (i_req.req_type == REQ_WRITE)
                         && ({20'd0, i_req.entry_index} < 32'(FAT_ENTRIES));
    assign w_start_oor = {20'd0, i_req.start_cluster} >= 32'(FAT_ENTRIES);

    // table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_req.entry_index[FAT_AW-1:0]] <= i_req.entry_value;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // step decode on the entry of the current cluster
    assign w_is_end     = r_rd_data >= END_MIN;
    assign w_is_bad     = r_rd_data == BAD_MARK;
    assign w_count_done = (r_cnt + 1'b1) == r_limit;
    assign w_next_oor   = {4'd0, r_rd_data} >= 32'(FAT_ENTRIES);

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cl        = r_cl;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_lim_st    = r_lim_st;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_rd_addr   = r_rd_data[FAT_AW-1:0];
        case (r_state)
            S_IDLE: begin
                w_rd_addr = i_req.start_cluster[FAT_AW-1:0];
                if (w_accept && i_req.req_type == REQ_WALK) begin
                    n_cl  = {{(ENTRY_W-CLUSTER_W){1'b0}}, i_req.start_cluster};
                    n_cnt = '0;
                    if (i_req.run_length == '0 || i_req.run_length > RUN_W'(MAX_RUN)) begin
                        n_limit  = CNT_W'(MAX_RUN);
                        n_lim_st = ST_CAP;
                    end else begin
                        n_limit  = i_req.run_length[CNT_W-1:0];
                        n_lim_st = ST_END;
                    end
                    if (w_start_oor) begin
                        n_out_valid = 1'b1;
                        n_out       = '{cluster_number: i_req.start_cluster,
                                        last: 1'b1, status: ST_RANGE};
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                n_out_valid          = 1'b1;
                n_out.cluster_number = r_cl[CLUSTER_W-1:0];
                n_out.last           = 1'b1;
                n_state              = S_IDLE;
                if (w_is_end) begin
                    n_out.status = ST_END;
                end else if (w_is_bad) begin
                    n_out.status = ST_BAD;
                end else if (w_count_done) begin
                    n_out.status = r_lim_st;
                end else if (w_next_oor) begin
                    n_out.status = ST_RANGE;
                end else begin
                    // follow the link; read address comes from the entry
                    n_out.last   = 1'b0;
                    n_out.status = ST_END;
                    n_state      = S_WALK;
                    n_cl         = r_rd_data;
                    n_cnt        = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cl     <= n_cl;
        r_cnt    <= n_cnt;
        r_limit  <= n_limit;
        r_lim_st <= n_lim_st;
        r_out    <= n_out;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // a result that is not the last is followed by another one
    a_chain_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.last |=> o_valid)
        else $error("non-final result not followed by another result");

    // only the final result can carry a nonzero status
    a_mid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.last |-> o_rsp.status == ST_END)
        else $error("status set on a non-final result");

    // the final result leaves the block ready
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.last |-> !busy)
        else $error("busy still high at final result");

    // a walk in progress always produces a result next cycle
    a_walk_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("walk step gave no result");

endmodule
